// ----- rtl/scfr_pkg.sv -----
package scfr_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned POS_W = 4;
  localparam int unsigned NUM_DATA = 6;
  localparam int unsigned DATA_IDX_W = 3;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [BYTE_W-1:0] HEAD_RESET = 8'h42;
  localparam logic [BYTE_W-1:0] TAIL_RESET = 8'h10;

  localparam logic [POS_W-1:0] POS_ADDR = 4'd1;
  localparam logic [POS_W-1:0] POS_DATA0 = 4'd3;
  localparam logic [POS_W-1:0] POS_LAST_SUM = 4'd8;
  localparam logic [POS_W-1:0] POS_CHK = 4'd9;
  localparam logic [POS_W-1:0] POS_TAIL = 4'd10;

  localparam logic [BYTE_W-1:0] ADDR_SPEED = 8'h01;
  localparam logic [BYTE_W-1:0] ADDR_GO_AROUND = 8'h02;
  localparam logic [BYTE_W-1:0] ADDR_BUSY_AREA = 8'h03;

  localparam logic [CFG_IDX_W-1:0] CFG_HEAD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TAIL = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_BAD_TAIL = 2'd1,
    STATUS_BAD_SUM  = 2'd2
  } status_e;

  typedef struct packed {
    logic             valid;
    logic [BYTE_W-1:0] data;
  } byte_req_t;

endpackage

// ----- rtl/scfr_in_reg.sv -----
module scfr_in_reg
  import scfr_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              rx_valid_i,
  input  logic [BYTE_W-1:0] rx_byte_i,
  output logic              rx_ready_o,
  input  logic              take_i,
  output byte_req_t         req_o
);

  logic              vld_q, vld_d;
  logic [BYTE_W-1:0] byte_q, byte_d;

  assign rx_ready_o = !vld_q || take_i;

  always_comb begin
    vld_d  = vld_q;
    byte_d = byte_q;
    if (rx_ready_o) begin
      vld_d  = rx_valid_i;
      byte_d = rx_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

  assign req_o.valid = vld_q;
  assign req_o.data  = byte_q;

endmodule

// ----- rtl/scfr_frame_core.sv -----
module scfr_frame_core
  import scfr_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [BYTE_W-1:0]    cfg_wdata_i,
  input  byte_req_t            req_i,
  output logic                 take_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [1:0]           status_o,
  output logic [7:0]           frame_address_o,
  output logic [31:0]          speed_bits_o,
  output logic signed [15:0]   steer_angle_o,
  output logic signed [15:0]   go_around_dir_o,
  output logic signed [15:0]   busy_area_dir_o
);

  logic [BYTE_W-1:0] head_q, tail_q;
  logic              active_q, active_d;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic [BYTE_W-1:0] sum_q, sum_d;
  logic [BYTE_W-1:0] addr_q, addr_d;
  logic [BYTE_W-1:0] chk_q, chk_d;
  logic [BYTE_W-1:0] data_q [NUM_DATA];
  logic [BYTE_W-1:0] data_d [NUM_DATA];
  logic [31:0]       speed_q, speed_d;
  logic [15:0]       angle_q, angle_d;
  logic [15:0]       go_q, go_d;
  logic [15:0]       busy_q, busy_d;
  logic              out_vld_q, out_vld_d;
  status_e           status_q, status_d;
  logic [BYTE_W-1:0] out_addr_q, out_addr_d;
  logic              complete;
  logic              out_free;
  logic [BYTE_W-1:0] b;
  logic [DATA_IDX_W-1:0] data_idx;

  assign b        = req_i.data;
  assign complete = active_q && (pos_q == POS_TAIL);
  assign out_free = !out_vld_q || out_ready_i;
  assign take_o   = req_i.valid && (!complete || out_free);
  assign data_idx = DATA_IDX_W'(pos_q - POS_DATA0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= HEAD_RESET;
      tail_q <= TAIL_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_HEAD: head_q <= cfg_wdata_i;
        CFG_TAIL: tail_q <= cfg_wdata_i;
        default:  head_q <= head_q;
      endcase
    end
  end

  always_comb begin
    active_d   = active_q;
    pos_d      = pos_q;
    sum_d      = sum_q;
    addr_d     = addr_q;
    chk_d      = chk_q;
    data_d     = data_q;
    speed_d    = speed_q;
    angle_d    = angle_q;
    go_d       = go_q;
    busy_d     = busy_q;
    status_d   = status_q;
    out_addr_d = out_addr_q;
    out_vld_d  = out_vld_q && !out_ready_i;
    if (take_o) begin
      if (!active_q) begin
        if (b == head_q) begin
          active_d = 1'b1;
          pos_d    = POS_ADDR;
          sum_d    = b;
        end
      end else if (complete) begin
        active_d   = 1'b0;
        pos_d      = '0;
        out_vld_d  = 1'b1;
        out_addr_d = addr_q;
        if (b != tail_q) begin
          status_d = STATUS_BAD_TAIL;
        end else if (sum_q != chk_q) begin
          status_d = STATUS_BAD_SUM;
        end else begin
          status_d = STATUS_OK;
          if (addr_q == ADDR_SPEED) begin
            speed_d = {data_q[3], data_q[2], data_q[1], data_q[0]};
            angle_d = {data_q[5], data_q[4]};
          end else if (addr_q == ADDR_GO_AROUND) begin
            go_d = {data_q[5], data_q[4]};
          end else if (addr_q == ADDR_BUSY_AREA) begin
            busy_d = {data_q[5], data_q[4]};
          end
        end
      end else begin
        pos_d = pos_q + 4'd1;
        if (pos_q <= POS_LAST_SUM) begin
          sum_d = sum_q + b;
        end
        if (pos_q == POS_ADDR) begin
          addr_d = b;
        end
        if (pos_q >= POS_DATA0 && pos_q <= POS_LAST_SUM) begin
          data_d[data_idx] = b;
        end
        if (pos_q == POS_CHK) begin
          chk_d = b;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q  <= 1'b0;
      pos_q     <= '0;
      out_vld_q <= 1'b0;
      speed_q   <= '0;
      angle_q   <= '0;
      go_q      <= '0;
      busy_q    <= '0;
    end else begin
      active_q  <= active_d;
      pos_q     <= pos_d;
      out_vld_q <= out_vld_d;
      speed_q   <= speed_d;
      angle_q   <= angle_d;
      go_q      <= go_d;
      busy_q    <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q      <= sum_d;
    addr_q     <= addr_d;
    chk_q      <= chk_d;
    data_q     <= data_d;
    status_q   <= status_d;
    out_addr_q <= out_addr_d;
  end

  assign out_valid_o     = out_vld_q;
  assign status_o        = status_q;
  assign frame_address_o = out_addr_q;
  assign speed_bits_o    = speed_q;
  assign steer_angle_o   = angle_q;
  assign go_around_dir_o = go_q;
  assign busy_area_dir_o = busy_q;

endmodule

// ----- rtl/serial_command_frame_receiver.sv -----
// The result register loads a result when the request carrying the tail byte is taken.
// One byte per cycle unless a tail byte stalls; input and result registers decouple the sides.
// A tail byte waits in the input register only while an earlier result is still unread.
// Reset is asynchronous and active low: the frame state and the held values clear to zero,
// and the head and tail registers return to 0x42 and 0x10.
module serial_command_frame_receiver
  import scfr_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [BYTE_W-1:0]    cfg_wdata_i,
  input  logic                 rx_valid_i,
  output logic                 rx_ready_o,
  input  logic [7:0]           rx_byte_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [1:0]           status_o,
  output logic [7:0]           frame_address_o,
  output logic [31:0]          speed_bits_o,
  output logic signed [15:0]   steer_angle_o,
  output logic signed [15:0]   go_around_dir_o,
  output logic signed [15:0]   busy_area_dir_o
);

  byte_req_t req;
  logic      take;

  scfr_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rx_valid_i (rx_valid_i),
    .rx_byte_i  (rx_byte_i),
    .rx_ready_o (rx_ready_o),
    .take_i     (take),
    .req_o      (req)
  );

  scfr_frame_core u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .req_i           (req),
    .take_o          (take),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (status_o),
    .frame_address_o (frame_address_o),
    .speed_bits_o    (speed_bits_o),
    .steer_angle_o   (steer_angle_o),
    .go_around_dir_o (go_around_dir_o),
    .busy_area_dir_o (busy_area_dir_o)
  );

endmodule

// ----- rtl/scfr_checker.sv -----
module scfr_props
  import scfr_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input logic [1:0]           status_o,
  input logic [7:0]           frame_address_o,
  input logic [31:0]          speed_bits_o,
  input logic signed [15:0]   steer_angle_o,
  input logic signed [15:0]   go_around_dir_o,
  input logic signed [15:0]   busy_area_dir_o
);

  a_reset_idle: assert property (@(posedge clk_i) !rst_ni |=> !out_valid_o)
    else $error("Result valid during reset.");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) &&
      $stable(frame_address_o))
    else $error("Stalled result changed.");

  a_values_move_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !($stable(speed_bits_o) && $stable(steer_angle_o) && $stable(go_around_dir_o) &&
      $stable(busy_area_dir_o)) |-> out_valid_o && status_o == STATUS_OK)
    else $error("Held values changed without an accepted frame.");

  a_bad_frame_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == STATUS_BAD_TAIL || status_o == STATUS_BAD_SUM) |->
      $stable(speed_bits_o) && $stable(steer_angle_o) && $stable(go_around_dir_o) &&
      $stable(busy_area_dir_o))
    else $error("A rejected frame changed a held value.");

endmodule

bind serial_command_frame_receiver scfr_props u_scfr_props (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .status_o        (status_o),
  .frame_address_o (frame_address_o),
  .speed_bits_o    (speed_bits_o),
  .steer_angle_o   (steer_angle_o),
  .go_around_dir_o (go_around_dir_o),
  .busy_area_dir_o (busy_area_dir_o)
);

// ----- dv/scfr_checker.sv -----
`timescale 1ns / 1ps

module scfr_checker
  import scfr_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [BYTE_W-1:0]    cfg_wdata_i,
  input  logic                 rx_valid_i,
  input  logic                 rx_ready_i,
  input  logic [7:0]           rx_byte_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  logic [1:0]           status_i,
  input  logic [7:0]           frame_address_i,
  input  logic [31:0]          speed_bits_i,
  input  logic signed [15:0]   steer_angle_i,
  input  logic signed [15:0]   go_around_dir_i,
  input  logic signed [15:0]   busy_area_dir_i,
  output int unsigned          error_count_o,
  output int unsigned          pending_o
);

  localparam int unsigned FRAME_BYTES = POS_TAIL + 1;

  typedef struct packed {
    status_e     status;
    logic [7:0]  addr;
    logic [31:0] speed;
    logic [15:0] angle;
    logic [15:0] go_around;
    logic [15:0] busy_area;
  } frame_result_t;

  frame_result_t result_q[$];
  frame_result_t oldest;

  logic [7:0]  head_q;
  logic [7:0]  tail_q;
  logic        in_frame;
  logic [3:0]  frame_pos;
  logic [7:0]  frame_buf [FRAME_BYTES];
  logic [31:0] speed_q;
  logic [15:0] angle_q;
  logic [15:0] go_around_q;
  logic [15:0] busy_area_q;
  int unsigned mismatches;

  initial begin
    error_count_o = 0;
    pending_o = 0;
    mismatches = 0;
  end

  task automatic compare(input string field, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
      mismatches++;
    end
  endtask

  task automatic take_byte(input logic [7:0] b);
    frame_result_t res;
    logic [7:0]    sum;
    if (!in_frame && b == head_q) begin
      in_frame = 1'b1;
      frame_buf[0] = b;
      frame_pos = 4'd1;
    end else if (in_frame && frame_pos < FRAME_BYTES) begin
      frame_buf[frame_pos] = b;
      frame_pos = frame_pos + 4'd1;
    end
    if (frame_pos == FRAME_BYTES) begin
      sum = 8'h00;
      for (int i = 0; i <= POS_LAST_SUM; i++) begin
        sum = sum + frame_buf[i];
      end
      if (frame_buf[POS_TAIL] != tail_q) begin
        res.status = STATUS_BAD_TAIL;
      end else if (sum != frame_buf[POS_CHK]) begin
        res.status = STATUS_BAD_SUM;
      end else begin
        res.status = STATUS_OK;
        if (frame_buf[POS_ADDR] == ADDR_SPEED) begin
          speed_q = {frame_buf[POS_DATA0 + 3], frame_buf[POS_DATA0 + 2],
                     frame_buf[POS_DATA0 + 1], frame_buf[POS_DATA0]};
          angle_q = {frame_buf[POS_DATA0 + 5], frame_buf[POS_DATA0 + 4]};
        end else if (frame_buf[POS_ADDR] == ADDR_GO_AROUND) begin
          go_around_q = {frame_buf[POS_DATA0 + 5], frame_buf[POS_DATA0 + 4]};
        end else if (frame_buf[POS_ADDR] == ADDR_BUSY_AREA) begin
          busy_area_q = {frame_buf[POS_DATA0 + 5], frame_buf[POS_DATA0 + 4]};
        end
      end
      res.addr = frame_buf[POS_ADDR];
      res.speed = speed_q;
      res.angle = angle_q;
      res.go_around = go_around_q;
      res.busy_area = busy_area_q;
      result_q.push_back(res);
      in_frame = 1'b0;
      frame_pos = 4'd0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q = HEAD_RESET;
      tail_q = TAIL_RESET;
      in_frame = 1'b0;
      frame_pos = 4'd0;
      speed_q = '0;
      angle_q = '0;
      go_around_q = '0;
      busy_area_q = '0;
      result_q.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (result_q.size() == 0) begin
          $error("result 0x%0h from address 0x%0h arrived with no request pending",
                 status_i, frame_address_i);
          mismatches++;
        end else begin
          oldest = result_q.pop_front();
          compare("status", 32'(oldest.status), 32'(status_i));
          compare("frame_address", 32'(oldest.addr), 32'(frame_address_i));
          compare("speed_bits", oldest.speed, speed_bits_i);
          compare("steer_angle", 32'(oldest.angle), 32'($unsigned(steer_angle_i)));
          compare("go_around_dir", 32'(oldest.go_around), 32'($unsigned(go_around_dir_i)));
          compare("busy_area_dir", 32'(oldest.busy_area), 32'($unsigned(busy_area_dir_i)));
        end
      end
      if (rx_valid_i && rx_ready_i) begin
        take_byte(rx_byte_i);
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_HEAD) begin
          head_q = cfg_wdata_i;
        end else if (cfg_idx_i == CFG_TAIL) begin
          tail_q = cfg_wdata_i;
        end
      end
    end
    error_count_o <= mismatches;
    pending_o <= result_q.size();
  end

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import scfr_pkg::*;

  typedef enum int {
    FRAME_GOOD,
    FRAME_BAD_TAIL,
    FRAME_BAD_SUM,
    FRAME_CUT
  } frame_kind_e;

  logic                 clk_i = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = CFG_HEAD;
  logic [BYTE_W-1:0]    cfg_wdata = '0;
  logic                 rx_valid = 1'b0;
  logic [7:0]           rx_byte = '0;
  logic                 out_ready = 1'b0;
  logic                 rx_ready;
  logic                 out_valid;
  logic [1:0]           status;
  logic [7:0]           frame_address;
  logic [31:0]          speed_bits;
  logic signed [15:0]   steer_angle;
  logic signed [15:0]   go_around_dir;
  logic signed [15:0]   busy_area_dir;
  int unsigned          errors;
  int unsigned          pending;

  logic [7:0] cur_head = HEAD_RESET;
  logic [7:0] cur_tail = TAIL_RESET;
  bit         in_idle = 1'b1;
  bit         out_idle = 1'b1;
  bit         hold_long = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  serial_command_frame_receiver i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata),
    .rx_valid_i      (rx_valid),
    .rx_ready_o      (rx_ready),
    .rx_byte_i       (rx_byte),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .status_o        (status),
    .frame_address_o (frame_address),
    .speed_bits_o    (speed_bits),
    .steer_angle_o   (steer_angle),
    .go_around_dir_o (go_around_dir),
    .busy_area_dir_o (busy_area_dir)
  );

  scfr_checker i_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata),
    .rx_valid_i      (rx_valid),
    .rx_ready_i      (rx_ready),
    .rx_byte_i       (rx_byte),
    .out_valid_i     (out_valid),
    .out_ready_i     (out_ready),
    .status_i        (status),
    .frame_address_i (frame_address),
    .speed_bits_i    (speed_bits),
    .steer_angle_i   (steer_angle),
    .go_around_dir_i (go_around_dir),
    .busy_area_dir_i (busy_area_dir),
    .error_count_o   (errors),
    .pending_o       (pending)
  );

  task automatic send_byte(input logic [7:0] b);
    if (in_idle && $urandom_range(0, 3) == 0) begin
      rx_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    rx_valid <= 1'b1;
    rx_byte <= b;
    do @(posedge clk_i); while (!rx_ready);
  endtask

  task automatic send_frame(input logic [7:0] addr, input logic [7:0] spare,
                            input logic [47:0] payload, input frame_kind_e kind);
    logic [7:0] fr [POS_TAIL + 1];
    logic [7:0] sum;
    int         n;
    fr[0] = cur_head;
    fr[POS_ADDR] = addr;
    fr[2] = spare;
    for (int i = 0; i < NUM_DATA; i++) begin
      fr[POS_DATA0 + i] = payload[8 * i +: 8];
    end
    sum = 8'h00;
    for (int i = 0; i <= POS_LAST_SUM; i++) begin
      sum = sum + fr[i];
    end
    fr[POS_CHK] = sum;
    fr[POS_TAIL] = cur_tail;
    n = POS_TAIL + 1;
    case (kind)
      FRAME_BAD_TAIL: fr[POS_TAIL] = fr[POS_TAIL] ^ 8'($urandom_range(1, 255));
      FRAME_BAD_SUM:  fr[POS_CHK] = fr[POS_CHK] ^ 8'($urandom_range(1, 255));
      FRAME_CUT:      n = $urandom_range(1, POS_TAIL);
      default: ;
    endcase
    for (int i = 0; i < n; i++) begin
      send_byte(fr[i]);
    end
  endtask

  task automatic send_noise();
    logic [7:0] b;
    repeat ($urandom_range(1, 3)) begin
      do b = 8'($urandom); while (b == cur_head);
      send_byte(b);
    end
  endtask

  // Closes any open frame with bytes that cannot start a new one, then waits until
  // every expected result has been read and the block has settled.
  task automatic settle();
    repeat (POS_TAIL) send_byte(~cur_head);
    rx_valid <= 1'b0;
    repeat (4) @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic set_markers(input logic [7:0] head, input logic [7:0] tail);
    cfg_we <= 1'b1;
    cfg_idx <= CFG_HEAD;
    cfg_wdata <= head;
    @(posedge clk_i);
    cfg_idx <= CFG_TAIL;
    cfg_wdata <= tail;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    cur_head = head;
    cur_tail = tail;
  endtask

  task automatic random_frames(input int count);
    int          pick;
    logic [7:0]  addr;
    frame_kind_e kind;
    repeat (count) begin
      if ($urandom_range(0, 3) == 0) begin
        send_noise();
      end
      pick = $urandom_range(0, 9);
      if (pick < 3) begin
        addr = ADDR_SPEED;
      end else if (pick < 5) begin
        addr = ADDR_GO_AROUND;
      end else if (pick < 7) begin
        addr = ADDR_BUSY_AREA;
      end else begin
        addr = 8'($urandom);
      end
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
        kind = FRAME_BAD_TAIL;
      end else if (pick == 1) begin
        kind = FRAME_BAD_SUM;
      end else if (pick == 2) begin
        kind = FRAME_CUT;
      end else begin
        kind = FRAME_GOOD;
      end
      send_frame(addr, 8'($urandom), {16'($urandom), 32'($urandom)}, kind);
    end
  endtask

  initial begin
    while (!rst_n) @(posedge clk_i);
    forever begin
      if (hold_long) begin
        hold_long = 1'b0;
        out_ready <= 1'b0;
        repeat (300) @(posedge clk_i);
      end else if (out_idle && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end
    end
  end

  initial begin
    logic [7:0] v;
    repeat (10) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(TAIL_RESET);
    send_frame(ADDR_SPEED, 8'hFF, 48'h8000_FFFF_FFFF, FRAME_GOOD);
    send_frame(ADDR_SPEED, 8'h00, 48'h7FFF_0000_0000, FRAME_GOOD);
    send_frame(ADDR_GO_AROUND, 8'h00, 48'h8000_1234_5678, FRAME_GOOD);
    send_frame(ADDR_BUSY_AREA, 8'h00, 48'h7FFF_0000_0000, FRAME_GOOD);
    send_frame(8'hFF, 8'hA5, 48'h0102_0304_0506, FRAME_GOOD);
    send_frame(8'h00, 8'h5A, 48'hFFFF_FFFF_FFFF, FRAME_GOOD);
    send_frame(ADDR_SPEED, 8'h00, 48'h1111_2222_3333, FRAME_BAD_TAIL);
    send_frame(ADDR_GO_AROUND, 8'h00, 48'h4444_5555_6666, FRAME_BAD_SUM);
    send_frame(ADDR_BUSY_AREA, HEAD_RESET, {6{HEAD_RESET}}, FRAME_GOOD);
    settle();

    set_markers(8'h00, 8'hFF);
    random_frames(10);
    settle();

    set_markers(8'hFF, 8'h00);
    random_frames(10);
    settle();

    in_idle = 1'b0;
    set_markers(8'($urandom), 8'($urandom));
    hold_long = 1'b1;
    random_frames(12);
    settle();
    in_idle = 1'b1;

    set_markers(8'($urandom), 8'($urandom));
    random_frames(14);
    settle();

    v = 8'($urandom);
    set_markers(v, v);
    random_frames(6);
    settle();

    in_idle = 1'b0;
    out_idle = 1'b0;
    set_markers(HEAD_RESET, TAIL_RESET);
    random_frames(12);
    settle();

    if (errors == 0) begin
      $display("serial_command_frame_receiver test passed");
    end else begin
      $display("serial_command_frame_receiver test failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("serial_command_frame_receiver test failed");
    $finish;
  end

endmodule
